### rtl/core/oass_pkg.sv
// Shared types and constants for the output activation scale/shift block.
// Used by oass_exp, oass_sqrt, oass_div and the top level; depends on nothing.
package oass_pkg;

   localparam int CHANNELS     = 8;
   localparam int HORNER_STEPS = 8;
   localparam int SQRT_BITS    = 16;
   localparam int QUOT_BITS    = 14;

   // Pipeline depths of the arithmetic units.
   localparam int EXP_LAT  = 2 + 3 * HORNER_STEPS + 1;
   localparam int SQRT_LAT = 1 + SQRT_BITS + 1;
   localparam int DIV_LAT  = QUOT_BITS;
   localparam int PIPE_LAT = EXP_LAT + DIV_LAT;
   localparam int SQRT_DLY = PIPE_LAT - SQRT_LAT;

   localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [30:0] SQRT_BIAS = 31'h0100_0000;
   localparam logic [63:0] SCALE_RESET = 64'h1000_1000_1000_1000;

   // Horner divisors from 8 down to 1 and floor(2^32 / k) for each.
   localparam logic [3:0] DIVISOR [HORNER_STEPS] = '{
      4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1};
   localparam logic [32:0] RECIP_Q32 [HORNER_STEPS] = '{
      33'd536870912, 33'd613566756, 33'd715827882, 33'd858993459,
      33'd1073741824, 33'd1431655765, 33'd2147483648, 33'd4294967296};

   typedef enum logic [2:0] {
      MODE_IDENTITY = 3'd0,
      MODE_ABS      = 3'd1,
      MODE_SOFTPLUS = 3'd2,
      MODE_TANH     = 3'd3,
      MODE_SIGMOID  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CSR_MODES    = 3'd0,
      CSR_SCALE_LO = 3'd1,
      CSR_SCALE_HI = 3'd2,
      CSR_SHIFT_LO = 3'd3,
      CSR_SHIFT_HI = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [29:0] u;
      logic [5:0]  n;
   } exp_ctx_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic [2:0]         ch;
      mode_type           mode;
      logic signed [15:0] scale;
      logic signed [15:0] shift;
   } sideband_type;

endpackage

### rtl/core/oass_exp.sv
// Pipelined e^-(y/4096) in Q.30: base-2 split, then an 8-term Horner series.
// Depends on oass_pkg.
module oass_exp import oass_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [16:0] y,
   output logic [30:0] e
);

   logic [47:0]  p_ff;
   logic [59:0]  u_prod;
   exp_ctx_type  ctx0_in;
   exp_ctx_type  ctx0_ff;
   exp_ctx_type  ctx_src [HORNER_STEPS];
   exp_ctx_type  ctxa_ff [HORNER_STEPS];
   exp_ctx_type  ctxb_ff [HORNER_STEPS];
   exp_ctx_type  ctxc_ff [HORNER_STEPS];
   logic [30:0]  acc_src [HORNER_STEPS];
   logic [30:0]  acc_in  [HORNER_STEPS];
   logic [30:0]  acc_ff  [HORNER_STEPS];
   logic [29:0]  va_in   [HORNER_STEPS];
   logic [29:0]  va_ff   [HORNER_STEPS];
   logic [29:0]  vb_ff   [HORNER_STEPS];
   logic [29:0]  qe_in   [HORNER_STEPS];
   logic [29:0]  qe_ff   [HORNER_STEPS];
   logic [30:0]  e_ff;

   always_comb begin
      u_prod     = 60'(p_ff[41:12]) * 60'(LN2_Q30);
      ctx0_in.u  = u_prod[59:30];
      ctx0_in.n  = p_ff[47:42];
   end

   // Each Horner step: multiply, reciprocal multiply, then one correction.
   always_comb begin
      logic [60:0] m;
      logic [62:0] mq;
      logic [32:0] back;
      logic [32:0] diff;
      logic [29:0] q;
      acc_src[0] = ONE_Q30;
      ctx_src[0] = ctx0_ff;
      for (int j = 1; j < HORNER_STEPS; j++) begin
         acc_src[j] = acc_ff[j-1];
         ctx_src[j] = ctxc_ff[j-1];
      end
      for (int j = 0; j < HORNER_STEPS; j++) begin
         m        = 61'(ctx_src[j].u) * 61'(acc_src[j]);
         va_in[j] = m[59:30];
         mq       = 63'(va_ff[j]) * 63'(RECIP_Q32[j]);
         qe_in[j] = mq[61:32];
         back     = 33'(qe_ff[j]) * 33'(DIVISOR[j]);
         diff     = 33'(vb_ff[j]) - back;
         q        = (diff >= 33'(DIVISOR[j])) ? qe_ff[j] + 30'd1 : qe_ff[j];
         acc_in[j] = ONE_Q30 - 31'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= 48'(y) * 48'(LOG2E_Q30);
         ctx0_ff <= ctx0_in;
         for (int j = 0; j < HORNER_STEPS; j++) begin
            va_ff[j]   <= va_in[j];
            ctxa_ff[j] <= ctx_src[j];
            vb_ff[j]   <= va_ff[j];
            qe_ff[j]   <= qe_in[j];
            ctxb_ff[j] <= ctxa_ff[j];
            acc_ff[j]  <= acc_in[j];
            ctxc_ff[j] <= ctxb_ff[j];
         end
         if (ctxc_ff[HORNER_STEPS-1].n > 6'd30) begin
            e_ff <= '0;
         end else begin
            e_ff <= acc_ff[HORNER_STEPS-1] >> ctxc_ff[HORNER_STEPS-1].n;
         end
      end
   end

   assign e = e_ff;

endmodule

### rtl/core/oass_sqrt.sv
// Pipelined rounded square root of 2^24 + ax*ax, one root bit per stage.
// Depends on oass_pkg.
module oass_sqrt import oass_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] ax,
   output logic [15:0] root
);

   logic [30:0] s_ff;
   logic [30:0] rem_src [SQRT_BITS];
   logic [15:0] r_src   [SQRT_BITS];
   logic [30:0] rem_in  [SQRT_BITS];
   logic [15:0] r_in    [SQRT_BITS];
   logic [30:0] rem_ff  [SQRT_BITS];
   logic [15:0] r_ff    [SQRT_BITS];
   logic [15:0] root_ff;

   // The remainder s - r*r is kept; a trial bit is accepted when it fits.
   always_comb begin
      logic [31:0] test;
      rem_src[0] = s_ff;
      r_src[0]   = '0;
      for (int j = 1; j < SQRT_BITS; j++) begin
         rem_src[j] = rem_ff[j-1];
         r_src[j]   = r_ff[j-1];
      end
      for (int j = 0; j < SQRT_BITS; j++) begin
         test = (32'(r_src[j]) << (SQRT_BITS - j))
              + (32'd1 << (2 * (SQRT_BITS - 1 - j)));
         if (32'(rem_src[j]) >= test) begin
            rem_in[j] = 31'(32'(rem_src[j]) - test);
            r_in[j]   = r_src[j] | (16'd1 << (SQRT_BITS - 1 - j));
         end else begin
            rem_in[j] = rem_src[j];
            r_in[j]   = r_src[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= SQRT_BIAS + 31'(ax) * 31'(ax);
         for (int j = 0; j < SQRT_BITS; j++) begin
            rem_ff[j] <= rem_in[j];
            r_ff[j]   <= r_in[j];
         end
         if (rem_ff[SQRT_BITS-1] > 31'(r_ff[SQRT_BITS-1])) begin
            root_ff <= r_ff[SQRT_BITS-1] + 16'd1;
         end else begin
            root_ff <= r_ff[SQRT_BITS-1];
         end
      end
   end

   assign root = root_ff;

endmodule

### rtl/core/oass_div.sv
// Pipelined restoring divider, one quotient bit per stage (quotient < 2^14).
// Depends on oass_pkg.
module oass_div import oass_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [43:0] num,
   input  logic [31:0] den,
   output logic [13:0] quot
);

   logic [43:0] rem_src [QUOT_BITS];
   logic [31:0] den_src [QUOT_BITS];
   logic [13:0] q_src   [QUOT_BITS];
   logic [43:0] rem_in  [QUOT_BITS];
   logic [13:0] q_in    [QUOT_BITS];
   logic [43:0] rem_ff  [QUOT_BITS];
   logic [31:0] den_ff  [QUOT_BITS];
   logic [13:0] q_ff    [QUOT_BITS];

   always_comb begin
      logic [45:0] trial;
      rem_src[0] = num;
      den_src[0] = den;
      q_src[0]   = '0;
      for (int j = 1; j < QUOT_BITS; j++) begin
         rem_src[j] = rem_ff[j-1];
         den_src[j] = den_ff[j-1];
         q_src[j]   = q_ff[j-1];
      end
      for (int j = 0; j < QUOT_BITS; j++) begin
         trial = 46'(den_src[j]) << (QUOT_BITS - 1 - j);
         if (46'(rem_src[j]) >= trial) begin
            rem_in[j] = 44'(46'(rem_src[j]) - trial);
            q_in[j]   = q_src[j] | (14'd1 << (QUOT_BITS - 1 - j));
         end else begin
            rem_in[j] = rem_src[j];
            q_in[j]   = q_src[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < QUOT_BITS; j++) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= den_src[j];
            q_ff[j]   <= q_in[j];
         end
      end
   end

   assign quot = q_ff[QUOT_BITS-1];

endmodule

### rtl/core/output_activation_scale_shift.sv
// Output activation unit: per-channel transform, Q4.12 scale, integer shift, saturation.
// One item per cycle is sustained while no result waits for transfer.
// The depth is set by the exponential (27 stages) followed by the divider (14 stages).
// The whole pipeline advances together and holds while a result waits for transfer.
// Synchronous reset clears the valid bits and restores the register defaults.
module output_activation_scale_shift import oass_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_sample_in,
   input  logic [2:0]         req_channel_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_value_out,
   output logic [2:0]         rsp_channel_out,
   output logic               rsp_saturated,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   logic [23:0] modes_ff;
   logic [63:0] scale_lo_ff, scale_hi_ff, shift_lo_ff, shift_hi_ff;

   logic               en;
   logic               in_vld_ff;
   logic signed [15:0] in_x_ff;
   logic [2:0]         in_ch_ff;

   sideband_type       sb_cur;
   logic [63:0]        scale_word, shift_word;
   logic signed [16:0] x_ext;
   logic [15:0]        ax;
   logic [16:0]        exp_arg;

   logic               vld_ff [PIPE_LAT];
   sideband_type       sb_ff  [PIPE_LAT];
   logic [15:0]        r_dly_ff [SQRT_DLY];

   logic [30:0] e_val;
   logic [15:0] root;
   logic [13:0] quot;
   logic [42:0] num_half;
   logic [31:0] den;
   sideband_type sb_exp, sb_end;

   logic               t_vld_ff;
   logic signed [16:0] t_in, t_ff;
   logic [2:0]         t_ch_ff;
   logic signed [15:0] t_scale_ff, t_shift_ff;

   logic               m_vld_ff;
   logic signed [32:0] prod_ff;
   logic [2:0]         m_ch_ff;
   logic signed [15:0] m_shift_ff;

   logic signed [34:0] sum;
   logic signed [22:0] v;
   logic signed [15:0] v_sat;
   logic               sat;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_value_ff;
   logic [2:0]         rsp_ch_ff;
   logic               rsp_sat_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         modes_ff    <= '0;
         scale_lo_ff <= SCALE_RESET;
         scale_hi_ff <= SCALE_RESET;
         shift_lo_ff <= '0;
         shift_hi_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODES:    modes_ff    <= csr_wdata[23:0];
            CSR_SCALE_LO: scale_lo_ff <= csr_wdata;
            CSR_SCALE_HI: scale_hi_ff <= csr_wdata;
            CSR_SHIFT_LO: shift_lo_ff <= csr_wdata;
            CSR_SHIFT_HI: shift_hi_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Channel lookup on the registered input item.
   always_comb begin
      scale_word = in_ch_ff[2] ? scale_hi_ff : scale_lo_ff;
      shift_word = in_ch_ff[2] ? shift_hi_ff : shift_lo_ff;
      sb_cur.x   = in_x_ff;
      sb_cur.ch  = in_ch_ff;
      if (int'(in_ch_ff) < CHANNELS) begin
         sb_cur.mode  = mode_type'(modes_ff[5'(in_ch_ff) * 5'd3 +: 3]);
         sb_cur.scale = $signed(scale_word[{in_ch_ff[1:0], 4'b0} +: 16]);
         sb_cur.shift = $signed(shift_word[{in_ch_ff[1:0], 4'b0} +: 16]);
      end else begin
         sb_cur.mode  = MODE_IDENTITY;
         sb_cur.scale = 16'sh1000;
         sb_cur.shift = '0;
      end
      x_ext   = 17'(in_x_ff);
      ax      = 16'(x_ext < 0 ? -x_ext : x_ext);
      exp_arg = (sb_cur.mode == MODE_TANH) ? {ax, 1'b0} : {1'b0, ax};
   end

   oass_exp u_exp (
      .clock (clock),
      .en    (en),
      .y     (exp_arg),
      .e     (e_val)
   );

   oass_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .ax    (ax),
      .root  (root)
   );

   // Numerator and denominator of the sigmoid and tanh ratios.
   assign sb_exp = sb_ff[EXP_LAT-1];
   always_comb begin
      den = 32'(ONE_Q30) + 32'(e_val);
      case (sb_exp.mode)
         MODE_TANH:    num_half = 43'(ONE_Q30 - e_val) << 12;
         MODE_SIGMOID: num_half = sb_exp.x[15] ? (43'(e_val) << 12) : (43'd1 << 42);
         default:      num_half = '0;
      endcase
   end

   oass_div u_div (
      .clock (clock),
      .en    (en),
      .num   ({num_half, 1'b0}),
      .den   (den),
      .quot  (quot)
   );

   assign sb_end = sb_ff[PIPE_LAT-1];

   always_comb begin
      logic [12:0]        rd;
      logic signed [17:0] sp_sum;
      logic signed [16:0] xe;
      rd     = 13'((15'(quot) + 15'd1) >> 1);
      xe     = 17'(sb_end.x);
      sp_sum = 18'(sb_end.x) + $signed({2'b0, r_dly_ff[SQRT_DLY-1]}) + 18'sd1;
      case (sb_end.mode)
         MODE_ABS:      t_in = (xe < 0) ? -xe : xe;
         MODE_SOFTPLUS: t_in = 17'(sp_sum >>> 1);
         MODE_TANH:     t_in = sb_end.x[15] ? -$signed({4'b0, rd}) : $signed({4'b0, rd});
         MODE_SIGMOID:  t_in = $signed({4'b0, rd});
         default:       t_in = xe;
      endcase
   end

   // Final rounding: the shift is aligned to Q.12 and the sum rounds half up.
   always_comb begin
      sum = 35'(prod_ff) + (35'(m_shift_ff) <<< 12) + 35'sd2048;
      v   = 23'(sum >>> 12);
      if (v > 23'sd32767) begin
         v_sat = 16'sh7FFF;
         sat   = 1'b1;
      end else if (v < -23'sd32768) begin
         v_sat = -16'sh8000;
         sat   = 1'b1;
      end else begin
         v_sat = 16'(v);
         sat   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         t_vld_ff     <= 1'b0;
         m_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         in_vld_ff <= req_valid;
         vld_ff[0] <= in_vld_ff;
         for (int i = 1; i < PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         t_vld_ff     <= vld_ff[PIPE_LAT-1];
         m_vld_ff     <= t_vld_ff;
         rsp_valid_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_x_ff  <= req_sample_in;
         in_ch_ff <= req_channel_in;
         sb_ff[0] <= sb_cur;
         for (int i = 1; i < PIPE_LAT; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
         r_dly_ff[0] <= root;
         for (int i = 1; i < SQRT_DLY; i++) begin
            r_dly_ff[i] <= r_dly_ff[i-1];
         end
         t_ff       <= t_in;
         t_ch_ff    <= sb_end.ch;
         t_scale_ff <= sb_end.scale;
         t_shift_ff <= sb_end.shift;
         prod_ff    <= 33'(t_ff) * 33'(t_scale_ff);
         m_ch_ff    <= t_ch_ff;
         m_shift_ff <= t_shift_ff;
         rsp_value_ff <= v_sat;
         rsp_ch_ff    <= m_ch_ff;
         rsp_sat_ff   <= sat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_channel_out = rsp_ch_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

### tb/output_activation_scale_shift_tb.sv
// Self-checking testbench for output_activation_scale_shift: a scoreboard class
// predicts each result from the accepted input and the register settings.
// Depends on oass_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module output_activation_scale_shift_tb;
   import oass_pkg::*;

   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          DRAIN_CYCLES   = 60;
   localparam logic [2:0]  CSR_UNUSED     = 3'd7;
   localparam logic [63:0] Q30_ONE        = 64'd1 << 30;

   typedef struct {
      logic signed [15:0] value;
      logic [2:0]         channel;
      logic               saturated;
   } activation_result_type;

   class activation_scoreboard;
      logic [23:0]           modes_reg;
      logic [63:0]           scale_lo_reg, scale_hi_reg, shift_lo_reg, shift_hi_reg;
      activation_result_type expected_q[$];
      int                    errors;

      function new();
         modes_reg    = '0;
         scale_lo_reg = SCALE_RESET;
         scale_hi_reg = SCALE_RESET;
         shift_lo_reg = '0;
         shift_hi_reg = '0;
         errors       = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] data);
         case (idx)
            CSR_MODES:    modes_reg    = data[23:0];
            CSR_SCALE_LO: scale_lo_reg = data;
            CSR_SCALE_HI: scale_hi_reg = data;
            CSR_SHIFT_LO: shift_lo_reg = data;
            CSR_SHIFT_HI: shift_hi_reg = data;
            default: ;
         endcase
      endfunction

      // e^-(y/4096) in Q.30 for y >= 0.
      function bit [63:0] exp_neg(bit [63:0] y);
         bit [63:0] prod, n, frac, u, acc;
         prod = y * 64'(LOG2E_Q30);
         n    = prod >> 42;
         frac = (prod >> 12) & (Q30_ONE - 1);
         u    = (frac * 64'(LN2_Q30)) >> 30;
         acc  = Q30_ONE;
         for (int k = 8; k >= 1; k--) acc = Q30_ONE - ((u * acc) >> 30) / 64'(k);
         return (n > 30) ? 64'd0 : (acc >> n);
      endfunction

      function bit [63:0] sqrt_nearest(bit [63:0] s);
         bit [63:0] r, trial;
         r = 0;
         for (int b = 16; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= s) r = trial;
         end
         if (s - r * r > r) r++;
         return r;
      endfunction

      function bit [63:0] div_round(bit [63:0] num, bit [63:0] den);
         return ((num << 1) / den + 1) >> 1;
      endfunction

      function longint apply_mode(longint x, logic [2:0] mode);
         bit [63:0] ax, e;
         longint    t;
         ax = (x < 0) ? -x : x;
         case (mode_type'(mode))
            MODE_ABS: return longint'(ax);
            MODE_SOFTPLUS: begin
               t = x + longint'(sqrt_nearest((Q30_ONE >> 6) + ax * ax)) + 1;
               return t >>> 1;
            end
            MODE_TANH: begin
               e = exp_neg(2 * ax);
               t = longint'(div_round((Q30_ONE - e) << 12, Q30_ONE + e));
               return (x < 0) ? -t : t;
            end
            MODE_SIGMOID: begin
               e = exp_neg(ax);
               if (x >= 0) return longint'(div_round(Q30_ONE << 12, Q30_ONE + e));
               return longint'(div_round(e << 12, Q30_ONE + e));
            end
            default: return x;
         endcase
      endfunction

      function void note_input(logic signed [15:0] sample, logic [2:0] ch);
         activation_result_type res;
         logic [63:0]           scale_word, shift_word;
         logic [2:0]            mode;
         longint                scale, shift, sum, v;
         mode       = 3'(modes_reg >> (3 * ch));
         scale_word = (ch < 4) ? scale_lo_reg : scale_hi_reg;
         shift_word = (ch < 4) ? shift_lo_reg : shift_hi_reg;
         scale      = longint'($signed(16'(scale_word >> (16 * ch[1:0]))));
         shift      = longint'($signed(16'(shift_word >> (16 * ch[1:0]))));
         sum = apply_mode(longint'(sample), mode) * scale + shift * 4096 + 2048;
         v   = sum >>> 12;
         res.saturated = 1'b1;
         if (v > 32767) v = 32767;
         else if (v < -32768) v = -32768;
         else res.saturated = 1'b0;
         res.value   = 16'(v);
         res.channel = ch;
         expected_q.push_back(res);
      endfunction

      function void check_result(logic signed [15:0] value, logic [2:0] ch, logic sat);
         activation_result_type exp_res;
         if (expected_q.size() == 0) begin
            $error("unexpected result: value %0d channel %0d", value, ch);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (value !== exp_res.value) begin
            $error("value_out: expected %0d, got %0d", exp_res.value, value);
            errors++;
         end
         if (ch !== exp_res.channel) begin
            $error("channel_out: expected %0d, got %0d", exp_res.channel, ch);
            errors++;
         end
         if (sat !== exp_res.saturated) begin
            $error("saturated: expected %0d, got %0d", exp_res.saturated, sat);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_sample_in = '0;
   logic [2:0]         req_channel_in = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_value_out;
   logic [2:0]         rsp_channel_out;
   logic               rsp_saturated;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;

   activation_scoreboard sb = new();
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int rsp_hold_count = 0;
   int idle_cycles    = 0;

   output_activation_scale_shift dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Result side: check each transfer, then decide readiness for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_value_out, rsp_channel_out, rsp_saturated);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_count > 0) begin
         rsp_hold_count <= rsp_hold_count - 1;
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL output_activation_scale_shift");
         $finish;
      end
   end

   task automatic send_sample(logic signed [15:0] sample, logic [2:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample_in  <= sample;
      req_channel_in <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_input(sample, ch);
   endtask

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic write_csr(logic [2:0] idx, logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2, 3, 4: return 16'($signed($urandom_range(16384)) - 8192);
         5:       return 16'($signed($urandom_range(512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_lanes();
      logic [63:0] w;
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(5))
            0:       w[16*i +: 16] = 16'h7FFF;
            1:       w[16*i +: 16] = 16'h8000;
            2:       w[16*i +: 16] = 16'(16'h1000 + $urandom_range(1024) - 512);
            default: w[16*i +: 16] = 16'($urandom);
         endcase
      end
      return w;
   endfunction

   task automatic random_phases(int per_phase, bit with_pressure);
      int idle_set [4] = '{0, 45, 0, 11};
      int stall_set [4] = '{0, 0, 45, 11};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_set[p];
         rsp_stall_pct = stall_set[p];
         if (with_pressure && p == 0) rsp_hold_count <= 300;
         for (int i = 0; i < per_phase; i++)
            send_sample(pick_sample(), 3'($urandom_range(7)));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: identity, unit scale, zero shift.
      random_phases(15, 1'b0);
      wait_idle();

      // Channel c runs mode c, so the three unknown codes are covered too.
      write_csr(CSR_MODES, 64'hFAC688);
      csr_we <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (int c = 0; c < 8; c++) begin
         send_sample(16'sh8000, 3'(c));
         send_sample(16'sh7FFF, 3'(c));
         send_sample(16'sh0000, 3'(c));
      end
      random_phases(60, 1'b1);
      wait_idle();

      write_csr(CSR_SCALE_LO, 64'hFFFF_0000_8000_7FFF);
      write_csr(CSR_SCALE_HI, 64'h7FFF_0800_F000_1000);
      write_csr(CSR_SHIFT_LO, 64'h0001_0000_8000_7FFF);
      write_csr(CSR_SHIFT_HI, 64'h0000_C000_4000_FFFF);
      csr_we <= 1'b0;
      random_phases(60, 1'b0);
      wait_idle();

      write_csr(CSR_MODES, 64'($urandom));
      write_csr(CSR_SCALE_LO, pick_lanes());
      write_csr(CSR_SCALE_HI, pick_lanes());
      write_csr(CSR_SHIFT_LO, {$urandom, $urandom});
      write_csr(CSR_SHIFT_HI, {$urandom, $urandom});
      csr_we <= 1'b0;
      random_phases(60, 1'b0);
      wait_idle();

      // All unknown codes; a write to an unused index must change nothing.
      write_csr(CSR_MODES, 64'hFFFFFF);
      write_csr(CSR_SCALE_LO, pick_lanes());
      write_csr(CSR_UNUSED, '1);
      csr_we <= 1'b0;
      random_phases(60, 1'b0);
      wait_idle();

      write_csr(CSR_MODES, 64'h0);
      write_csr(CSR_SCALE_LO, 64'h0);
      write_csr(CSR_SCALE_HI, 64'h0);
      write_csr(CSR_SHIFT_LO, 64'h8000_7FFF_8000_7FFF);
      csr_we <= 1'b0;
      random_phases(30, 1'b0);
      wait_idle();

      for (int r = 0; r < 2; r++) begin
         write_csr(CSR_MODES, 64'($urandom));
         write_csr(CSR_SCALE_LO, pick_lanes());
         write_csr(CSR_SCALE_HI, pick_lanes());
         write_csr(CSR_SHIFT_LO, pick_lanes());
         write_csr(CSR_SHIFT_HI, pick_lanes());
         csr_we <= 1'b0;
         random_phases(36, 1'b0);
         wait_idle();
      end

      if (sb.errors == 0)
         $display("PASS output_activation_scale_shift");
      else
         $display("FAIL output_activation_scale_shift");
      $finish;
   end
endmodule

### files.f
rtl/core/oass_pkg.sv
rtl/core/oass_exp.sv
rtl/core/oass_sqrt.sv
rtl/core/oass_div.sv
rtl/core/output_activation_scale_shift.sv
tb/output_activation_scale_shift_tb.sv
